>>> rtl/sliding_window_linear_regression_core_assert.svh
`ifndef SLIDING_WINDOW_LINEAR_REGRESSION_CORE_ASSERT_SVH
`define SLIDING_WINDOW_LINEAR_REGRESSION_CORE_ASSERT_SVH
// Checks sampled on clk, masked while arst_n is low.
// Same-cycle implication.
`define SWLR_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swlr check failed");
// Next-cycle implication.
`define SWLR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swlr check failed");
`endif

>>> rtl/swlr_pkg.sv
`timescale 1ns / 1ps
package swlr_pkg;
	localparam int BW        = 192; // wide work word, holds every intermediate
	localparam int MUL_STEPS = 96;  // multiplier operands stay below 2^96
	localparam int CNT_W     = 8;
	localparam int SUM_W     = 41;  // sum of up to 511 32-bit values
	localparam int SQ_W      = 72;  // sum of up to 511 products
	localparam int WL_W      = 9;
	localparam int ONE_Q     = 65536;

	localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
	localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_CALC = 1'b1;

	typedef logic [1:0] op_t;
	localparam op_t OP_SUB = 2'd0;
	localparam op_t OP_MUL = 2'd1;
	localparam op_t OP_DIV = 2'd2;

	typedef logic [3:0] reg_sel_t;
	localparam reg_sel_t R_SX    = 4'd0;
	localparam reg_sel_t R_SY    = 4'd1;
	localparam reg_sel_t R_SXX   = 4'd2;
	localparam reg_sel_t R_SYY   = 4'd3;
	localparam reg_sel_t R_SXY   = 4'd4;
	localparam reg_sel_t R_N     = 4'd5;
	localparam reg_sel_t R_P     = 4'd6;
	localparam reg_sel_t R_D     = 4'd7;
	localparam reg_sel_t R_E     = 4'd8;
	localparam reg_sel_t R_T0    = 4'd9;
	localparam reg_sel_t R_T1    = 4'd10;
	localparam reg_sel_t R_K     = 4'd11;
	localparam reg_sel_t R_SLOPE = 4'd12;
	localparam reg_sel_t R_ICPT  = 4'd13;
	localparam reg_sel_t R_R2    = 4'd14;

	typedef logic [1:0] stat_code_t;
	localparam stat_code_t ST_OK    = 2'd0;
	localparam stat_code_t ST_EMPTY = 2'd1;
	localparam stat_code_t ST_XFLAT = 2'd2;
	localparam stat_code_t ST_YFLAT = 2'd3;

	typedef logic [4:0] pc_t;
	localparam pc_t PC_BRANCH     = 5'd8;
	localparam pc_t PC_XFLAT_FIRST = 5'd9;
	localparam pc_t PC_XFLAT_LAST = 5'd10;
	localparam pc_t PC_FIT_FIRST  = 5'd11;
	localparam pc_t PC_ICPT_DIV   = 5'd18;
	localparam pc_t PC_LAST       = 5'd22;

	typedef struct packed {
		op_t      op;
		reg_sel_t a;
		reg_sel_t b;
		reg_sel_t dst;
	} uop_t;

	typedef struct packed {
		logic            mem_we;
		logic            mem_re;
		logic            acc_clr;
		logic            res_clr;
		logic            op_start;
		uop_t            u;
		logic [WL_W-1:0] n;
	} dp_cmd_t;

	typedef struct packed {
		logic op_done;
		logic pipe_busy;
		logic d_zero;
		logic e_zero;
	} dp_stat_t;

	// Calculation program; b is always the narrower multiplier operand.
	function automatic uop_t uop(input pc_t pc);
		uop_t u;
		unique case (pc)
			5'd0:  u = '{OP_MUL, R_SXY, R_N,  R_T0};
			5'd1:  u = '{OP_MUL, R_SX,  R_SY, R_T1};
			5'd2:  u = '{OP_SUB, R_T0,  R_T1, R_P};
			5'd3:  u = '{OP_MUL, R_SXX, R_N,  R_T0};
			5'd4:  u = '{OP_MUL, R_SX,  R_SX, R_T1};
			5'd5:  u = '{OP_SUB, R_T0,  R_T1, R_D};
			5'd6:  u = '{OP_MUL, R_SYY, R_N,  R_T0};
			5'd7:  u = '{OP_MUL, R_SY,  R_SY, R_T1};
			5'd8:  u = '{OP_SUB, R_T0,  R_T1, R_E};
			5'd9:  u = '{OP_MUL, R_SY,  R_K,  R_T0};
			5'd10: u = '{OP_DIV, R_T0,  R_N,  R_ICPT};
			5'd11: u = '{OP_MUL, R_P,   R_K,  R_T0};
			5'd12: u = '{OP_DIV, R_T0,  R_D,  R_SLOPE};
			5'd13: u = '{OP_MUL, R_D,   R_SY, R_T0};
			5'd14: u = '{OP_MUL, R_P,   R_SX, R_T1};
			5'd15: u = '{OP_SUB, R_T0,  R_T1, R_T0};
			5'd16: u = '{OP_MUL, R_T0,  R_K,  R_T0};
			5'd17: u = '{OP_MUL, R_D,   R_N,  R_T1};
			5'd18: u = '{OP_DIV, R_T0,  R_T1, R_ICPT};
			5'd19: u = '{OP_MUL, R_P,   R_P,  R_T0};
			5'd20: u = '{OP_MUL, R_T0,  R_K,  R_T0};
			5'd21: u = '{OP_MUL, R_D,   R_E,  R_T1};
			5'd22: u = '{OP_DIV, R_T0,  R_T1, R_R2};
			default: u = '{OP_SUB, R_T0, R_T0, R_T0};
		endcase
		return u;
	endfunction
endpackage

>>> rtl/swlr_alu.sv
`timescale 1ns / 1ps
module swlr_alu import swlr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  op_t                  op,
	input  logic signed [BW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic                 done,
	output logic signed [BW-1:0] res
);
	localparam logic [2:0] A_IDLE = 3'd0;
	localparam logic [2:0] A_MUL  = 3'd1;
	localparam logic [2:0] A_MFIN = 3'd2;
	localparam logic [2:0] A_DIV  = 3'd3;
	localparam logic [2:0] A_RND  = 3'd4;
	localparam logic [2:0] A_SAT  = 3'd5;

	logic [2:0]       st_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic             done_q;
	logic [BW-1:0]    acc_q;  // product or partial remainder
	logic [BW-1:0]    shf_q;  // multiplier bits, or dividend then quotient
	logic [BW-1:0]    opnd_q; // multiplicand or divisor
	logic signed [BW-1:0] res_q;

	logic [BW-1:0] abs_a, abs_b, mul_sum;
	logic [BW:0]   trial, trial_sub;
	logic          trial_ge, rnd_up, q_big;
	logic signed [63:0] q64, s64;

	always_comb begin
		abs_a     = a[BW-1] ? BW'(-a) : BW'(a);
		abs_b     = b[BW-1] ? BW'(-b) : BW'(b);
		mul_sum   = {acc_q[BW-2:0], 1'b0} + (shf_q[MUL_STEPS-1] ? opnd_q : '0);
		trial     = {acc_q, shf_q[BW-1]};
		trial_ge  = trial >= {1'b0, opnd_q};
		trial_sub = trial - {1'b0, opnd_q};
		rnd_up    = {acc_q, 1'b0} >= {1'b0, opnd_q};
		q_big     = |shf_q[BW-1:63];
		q64       = shf_q[63:0];
		if (q_big)
			s64 = neg_q ? S64_MIN : S64_MAX;
		else
			s64 = neg_q ? -q64 : q64;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= A_IDLE;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				A_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						acc_q <= '0;
						case (op)
							OP_SUB: begin
								res_q  <= a - b;
								done_q <= 1'b1;
							end
							OP_MUL: begin
								neg_q  <= a[BW-1] ^ b[BW-1];
								opnd_q <= abs_a;
								shf_q  <= abs_b;
								st_q   <= A_MUL;
							end
							OP_DIV: begin
								neg_q  <= a[BW-1];
								shf_q  <= abs_a;
								opnd_q <= BW'(b);
								st_q   <= A_DIV;
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				A_MUL: begin
					acc_q <= mul_sum;
					shf_q <= {shf_q[BW-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(MUL_STEPS - 1))
						st_q <= A_MFIN;
				end
				A_MFIN: begin
					res_q  <= neg_q ? -$signed(acc_q) : $signed(acc_q);
					done_q <= 1'b1;
					st_q   <= A_IDLE;
				end
				A_DIV: begin
					acc_q <= trial_ge ? trial_sub[BW-1:0] : trial[BW-1:0];
					shf_q <= {shf_q[BW-2:0], trial_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(BW - 1))
						st_q <= A_RND;
				end
				A_RND: begin
					if (rnd_up)
						shf_q <= shf_q + 1'b1;
					st_q <= A_SAT;
				end
				A_SAT: begin
					res_q  <= BW'(s64);
					done_q <= 1'b1;
					st_q   <= A_IDLE;
				end
				default: st_q <= A_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;
endmodule

>>> rtl/swlr_dpath.sv
`timescale 1ns / 1ps
module swlr_dpath import swlr_pkg::*; #(
	parameter int MAX_WINDOW = 256,
	localparam int AW = $clog2(MAX_WINDOW)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	input  logic [AW-1:0]       mem_waddr,
	input  logic [AW-1:0]       mem_raddr,
	input  logic signed [31:0]  x_value,
	input  logic signed [31:0]  y_value,
	output dp_stat_t            stat,
	output logic signed [63:0]  slope,
	output logic signed [63:0]  intercept,
	output logic [16:0]         r_squared
);
	logic [63:0] smp_mem [MAX_WINDOW];
	logic [63:0] rd_s1;
	logic        v_s1, v_s2;
	logic signed [31:0] x_s2, y_s2;
	logic signed [63:0] xx_s2, yy_s2, xy_s2;
	logic signed [SUM_W-1:0] sx_q, sy_q;
	logic signed [SQ_W-1:0]  sxx_q, syy_q, sxy_q;
	logic signed [BW-1:0] p_q, d_q, e_q, t0_q, t1_q;
	logic signed [BW-1:0] opa, opb, a_q, b_q, alu_res;
	logic     go_q, alu_done;
	op_t      op_q;
	reg_sel_t dst_q;
	logic signed [63:0] slope_q, icpt_q;
	logic [16:0]        r2_q;

	// sample store: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.mem_we)
			smp_mem[mem_waddr] <= {x_value, y_value};
		rd_s1 <= smp_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			go_q <= 1'b0;
		end else begin
			v_s1 <= cmd.mem_re;
			v_s2 <= v_s1;
			go_q <= cmd.op_start;
		end
	end

	always_ff @(posedge clk) begin
		x_s2  <= $signed(rd_s1[63:32]);
		y_s2  <= $signed(rd_s1[31:0]);
		xx_s2 <= $signed(rd_s1[63:32]) * $signed(rd_s1[63:32]);
		yy_s2 <= $signed(rd_s1[31:0]) * $signed(rd_s1[31:0]);
		xy_s2 <= $signed(rd_s1[63:32]) * $signed(rd_s1[31:0]);
		if (cmd.acc_clr) begin
			sx_q  <= '0;
			sy_q  <= '0;
			sxx_q <= '0;
			syy_q <= '0;
			sxy_q <= '0;
		end else if (v_s2) begin
			sx_q  <= sx_q + SUM_W'(x_s2);
			sy_q  <= sy_q + SUM_W'(y_s2);
			sxx_q <= sxx_q + SQ_W'(xx_s2);
			syy_q <= syy_q + SQ_W'(yy_s2);
			sxy_q <= sxy_q + SQ_W'(xy_s2);
		end
	end

	always_comb begin
		unique case (cmd.u.a)
			R_SX:    opa = BW'(sx_q);
			R_SY:    opa = BW'(sy_q);
			R_SXX:   opa = BW'(sxx_q);
			R_SYY:   opa = BW'(syy_q);
			R_SXY:   opa = BW'(sxy_q);
			R_N:     opa = BW'($signed({1'b0, cmd.n}));
			R_P:     opa = p_q;
			R_D:     opa = d_q;
			R_E:     opa = e_q;
			R_T0:    opa = t0_q;
			R_T1:    opa = t1_q;
			R_K:     opa = BW'(ONE_Q);
			default: opa = '0;
		endcase
		unique case (cmd.u.b)
			R_SX:    opb = BW'(sx_q);
			R_SY:    opb = BW'(sy_q);
			R_SXX:   opb = BW'(sxx_q);
			R_SYY:   opb = BW'(syy_q);
			R_SXY:   opb = BW'(sxy_q);
			R_N:     opb = BW'($signed({1'b0, cmd.n}));
			R_P:     opb = p_q;
			R_D:     opb = d_q;
			R_E:     opb = e_q;
			R_T0:    opb = t0_q;
			R_T1:    opb = t1_q;
			R_K:     opb = BW'(ONE_Q);
			default: opb = '0;
		endcase
	end

	// operand fetch, then write-back of the unit's result
	always_ff @(posedge clk) begin
		if (cmd.op_start) begin
			a_q   <= opa;
			b_q   <= opb;
			op_q  <= cmd.u.op;
			dst_q <= cmd.u.dst;
		end
		if (cmd.res_clr) begin
			slope_q <= '0;
			icpt_q  <= '0;
			r2_q    <= '0;
		end else if (alu_done) begin
			unique case (dst_q)
				R_P:     p_q  <= alu_res;
				R_D:     d_q  <= alu_res;
				R_E:     e_q  <= alu_res;
				R_T0:    t0_q <= alu_res;
				R_T1:    t1_q <= alu_res;
				R_SLOPE: slope_q <= alu_res[63:0];
				R_ICPT:  icpt_q  <= alu_res[63:0];
				R_R2: begin
					if ($signed(alu_res[63:0]) > 64'sd65536)
						r2_q <= 17'(ONE_Q);
					else
						r2_q <= alu_res[16:0];
				end
				default: ;
			endcase
		end
	end

	swlr_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go_q),
		.op     (op_q),
		.a      (a_q),
		.b      (b_q),
		.done   (alu_done),
		.res    (alu_res)
	);

	assign stat.op_done   = alu_done;
	assign stat.pipe_busy = v_s1 | v_s2;
	assign stat.d_zero    = (d_q == '0);
	assign stat.e_zero    = (e_q == '0);
	assign slope          = slope_q;
	assign intercept      = icpt_q;
	assign r_squared      = r2_q;
endmodule

>>> rtl/swlr_ctrl.sv
`timescale 1ns / 1ps
`include "sliding_window_linear_regression_core_assert.svh"
module swlr_ctrl import swlr_pkg::*; #(
	parameter int MAX_WINDOW = 256,
	localparam int AW = $clog2(MAX_WINDOW)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            command,
	input  logic            wl_we,
	input  logic [WL_W-1:0] wl_data,
	output logic            busy,
	output logic            done,
	output logic [1:0]      status,
	output logic [WL_W-1:0] samples_used,
	output dp_cmd_t         cmd,
	output logic [AW-1:0]   mem_waddr,
	output logic [AW-1:0]   mem_raddr,
	input  dp_stat_t        stat
);
	localparam int WL_CAP = (MAX_WINDOW < 511) ? MAX_WINDOW : 511;
	localparam int WL_RST = (MAX_WINDOW < 256) ? MAX_WINDOW : 256;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WALK  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_ISSUE = 3'd3;
	localparam logic [2:0] S_WAIT  = 3'd4;

	logic [2:0]      state_q;
	logic [WL_W-1:0] wlen_q, filled_q, n_q, walk_q, wl_eff;
	logic [AW-1:0]   wp_q;
	pc_t             pc_q;
	stat_code_t      stat_q;
	logic            done_q;
	logic            accept, add_acc, calc_acc, wp_wrap;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start & ~busy;
	assign add_acc  = accept & (command == CMD_ADD);
	assign calc_acc = accept & (command == CMD_CALC);
	assign wp_wrap  = (WL_W'(wp_q) + WL_W'(1)) == wlen_q;

	always_comb begin
		wl_eff = wl_data;
		if (wl_data == '0)
			wl_eff = WL_W'(1);
		else if (wl_data > WL_W'(WL_CAP))
			wl_eff = WL_W'(WL_CAP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q   <= WL_W'(WL_RST);
			wp_q     <= '0;
			filled_q <= '0;
			state_q  <= S_IDLE;
			n_q      <= '0;
			walk_q   <= '0;
			pc_q     <= '0;
			stat_q   <= ST_OK;
			done_q   <= 1'b0;
		end else begin
			if (wl_we) begin
				wlen_q   <= wl_eff;
				wp_q     <= '0;
				filled_q <= '0;
			end else if (add_acc) begin
				wp_q <= wp_wrap ? '0 : wp_q + 1'b1;
				if (filled_q < wlen_q)
					filled_q <= filled_q + 1'b1;
			end
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (calc_acc) begin
						n_q    <= filled_q;
						walk_q <= '0;
						pc_q   <= '0;
						if (filled_q == '0) begin
							stat_q <= ST_EMPTY;
							done_q <= 1'b1;
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					walk_q <= walk_q + 1'b1;
					if (walk_q == n_q - 1'b1)
						state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (!stat.pipe_busy)
						state_q <= S_ISSUE;
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if (stat.op_done) begin
						state_q <= S_ISSUE;
						pc_q    <= pc_q + 1'b1;
						if (pc_q == PC_BRANCH) begin
							pc_q <= stat.d_zero ? PC_XFLAT_FIRST : PC_FIT_FIRST;
						end else if (pc_q == PC_XFLAT_LAST) begin
							stat_q  <= ST_XFLAT;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (pc_q == PC_ICPT_DIV && stat.e_zero) begin
							stat_q  <= ST_YFLAT;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (pc_q == PC_LAST) begin
							stat_q  <= ST_OK;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.mem_we   = add_acc;
		cmd.mem_re   = (state_q == S_WALK);
		cmd.acc_clr  = calc_acc;
		cmd.res_clr  = calc_acc;
		cmd.op_start = (state_q == S_ISSUE);
		cmd.u        = uop(pc_q);
		cmd.n        = n_q;
	end

	assign mem_waddr    = wp_q;
	assign mem_raddr    = AW'(walk_q);
	assign done         = done_q;
	assign status       = stat_q;
	assign samples_used = n_q;

	`SWLR_ASSERT_SAME(a_fill_bound, 1'b1, filled_q <= wlen_q)
	`SWLR_ASSERT_SAME(a_done_idle, done_q, state_q == S_IDLE)
	`SWLR_ASSERT_SAME(a_opdone_wait, stat.op_done, state_q == S_WAIT)
	`SWLR_ASSERT_SAME(a_pipe_walk, stat.pipe_busy, state_q == S_WALK || state_q == S_DRAIN)
	`SWLR_ASSERT_NEXT(a_calc_busy, calc_acc && filled_q != '0, busy)
endmodule

>>> rtl/sliding_window_linear_regression_core.sv
`timescale 1ns / 1ps
// Sliding-window least-squares line fit over the last window_length (x,y) samples.
// Command channel: a beat is taken on a rising edge with start high and busy low.
//   command 0 stores (x_value, y_value) in the sample ring; it gives no result
//   and busy stays low, so adds may follow back to back.
//   command 1 fits the window; unless it is empty, busy rises for the whole fit.
// Result channel: done is high for exactly one cycle; slope, intercept
//   (signed Q47.16), r_squared (Q1.16), samples_used and status are valid with it.
//   The receiver cannot stall and done is not repeated; outputs hold until a new fit.
// Calculation: a window walk and pipeline drain (one sample a cycle through the
//   sample RAM port and three 32x32 multipliers), then a program of multiplies,
//   subtracts and divisions on one shared bit-serial wide unit. A window with all
//   x or all y equal ends the program early; an empty window skips walk and program.
// window_length_we writes window_length (0 taken as 1, capped at MAX_WINDOW) and
//   empties the window; write it only while idle.
// Reset: window length min(256, MAX_WINDOW), window empty. Sample RAM is not
//   cleared; only written entries are ever summed.
module sliding_window_linear_regression_core import swlr_pkg::*; #(
	parameter int MAX_WINDOW = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               command,
	input  logic signed [31:0] x_value,
	input  logic signed [31:0] y_value,
	input  logic               window_length_we,
	input  logic [8:0]         window_length,
	output logic               done,
	output logic signed [63:0] slope,
	output logic signed [63:0] intercept,
	output logic [16:0]        r_squared,
	output logic [8:0]         samples_used,
	output logic [1:0]         status
);
	localparam int AW = $clog2(MAX_WINDOW);

	dp_cmd_t       cmd;     // controller to datapath
	dp_stat_t      stat;    // datapath to controller
	logic [AW-1:0] mem_waddr, mem_raddr;

	// sequencer: window bookkeeping, walk counter, program counter
	swlr_ctrl #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.command      (command),
		.wl_we        (window_length_we),
		.wl_data      (window_length),
		.busy         (busy),
		.done         (done),
		.status       (status),
		.samples_used (samples_used),
		.cmd          (cmd),
		.mem_waddr    (mem_waddr),
		.mem_raddr    (mem_raddr),
		.stat         (stat)
	);

	// sample RAM, sum pipeline, wide registers and the mul/div unit
	swlr_dpath #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.mem_waddr (mem_waddr),
		.mem_raddr (mem_raddr),
		.x_value   (x_value),
		.y_value   (y_value),
		.stat      (stat),
		.slope     (slope),
		.intercept (intercept),
		.r_squared (r_squared)
	);
endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import swlr_pkg::*;

	// wide enough for every product the fit builds (largest is below 2^175)
	typedef logic signed [255:0] wide_t;

	typedef struct {
		logic signed [63:0] slope;
		logic signed [63:0] icpt;
		logic [16:0]        r2;
		logic [8:0]         n;
		stat_code_t         st;
	} fit_t;

	localparam int DEPTH = 256;
	localparam longint LIMIT = 20000000;

	// Line-fit predictor plus the queue of fits still owed by the block.
	class fit_scoreboard;
		logic signed [31:0] xs [DEPTH];
		logic signed [31:0] ys [DEPTH];
		int unsigned wpos, fill, wlen;
		fit_t owed [$];
		int mismatches;

		function new();
			wpos = 0;
			fill = 0;
			wlen = DEPTH;
			mismatches = 0;
		endfunction

		function void set_length(logic [8:0] v);
			int unsigned l;
			l = v;
			if (l == 0)
				l = 1;
			if (l > DEPTH)
				l = DEPTH;
			wlen = l;
			wpos = 0;
			fill = 0;
		endfunction

		// round to nearest, ties away from zero, den > 0, saturating
		function logic signed [63:0] round_div(wide_t num, wide_t den);
			logic neg;
			wide_t a, q, r;
			neg = num < 0;
			a = neg ? -num : num;
			q = a / den;
			r = a % den;
			if (2 * r >= den)
				q = q + 1;
			if (q > wide_t'(S64_MAX))
				return neg ? S64_MIN : S64_MAX;
			return neg ? -q[63:0] : q[63:0];
		endfunction

		function void note_beat(logic cmd, logic signed [31:0] x, logic signed [31:0] y);
			fit_t f;
			wide_t sx, sy, sxx, syy, sxy, xw, yw, bn, p, d, e, r2;
			int unsigned n;
			if (cmd == CMD_ADD) begin
				xs[wpos] = x;
				ys[wpos] = y;
				if (fill < wlen)
					fill++;
				wpos = (wpos + 1) % wlen;
				return;
			end
			n = (fill > wlen) ? wlen : fill;
			sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
			for (int i = 0; i < n; i++) begin
				xw = xs[i];
				yw = ys[i];
				sx += xw;
				sy += yw;
				sxx += xw * xw;
				syy += yw * yw;
				sxy += xw * yw;
			end
			f.slope = 0;
			f.icpt = 0;
			f.r2 = 0;
			f.n = 9'(n);
			f.st = ST_OK;
			if (n == 0) begin
				f.st = ST_EMPTY;
			end else begin
				bn = n;
				p = bn * sxy - sx * sy;
				d = bn * sxx - sx * sx;
				e = bn * syy - sy * sy;
				if (d == 0) begin
					f.st = ST_XFLAT;
					f.icpt = round_div(sy * 65536, bn);
				end else begin
					f.slope = round_div(p * 65536, d);
					f.icpt = round_div((sy * d - sx * p) * 65536, bn * d);
					if (e == 0) begin
						f.st = ST_YFLAT;
					end else begin
						r2 = round_div(p * p * 65536, d * e);
						if (r2 > ONE_Q)
							r2 = ONE_Q;
						if (r2 < 0)
							r2 = 0;
						f.r2 = r2[16:0];
					end
				end
			end
			owed.push_back(f);
		endfunction

		function void check_fit(logic signed [63:0] s, logic signed [63:0] c,
				logic [16:0] r, logic [8:0] n, logic [1:0] st);
			fit_t f;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: slope %0d status %0d", s, st);
				return;
			end
			f = owed.pop_front();
			if (s !== f.slope || c !== f.icpt || r !== f.r2 || n !== f.n || st !== f.st) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"fit mismatch: exp s=%0d c=%0d r2=%0d n=%0d st=%0d",
						" got s=%0d c=%0d r2=%0d n=%0d st=%0d"},
						f.slope, f.icpt, f.r2, f.n, f.st, s, c, r, n, st);
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               start = 0;
	logic               busy;
	logic               command = CMD_ADD;
	logic signed [31:0] x_value = 0;
	logic signed [31:0] y_value = 0;
	logic               window_length_we = 0;
	logic [8:0]         window_length = 0;
	logic               done;
	logic signed [63:0] slope;
	logic signed [63:0] intercept;
	logic [16:0]        r_squared;
	logic [8:0]         samples_used;
	logic [1:0]         status;

	fit_scoreboard sb = new();
	longint cycles = 0;
	int burst_left = 0;
	int beats = 0;

	sliding_window_linear_regression_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .x_value(x_value), .y_value(y_value),
		.window_length_we(window_length_we), .window_length(window_length),
		.done(done), .slope(slope), .intercept(intercept), .r_squared(r_squared),
		.samples_used(samples_used), .status(status)
	);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result beats cannot be held off: take every done cycle
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_fit(slope, intercept, r_squared, samples_used, status);
	end

	// one command beat; within a burst start stays high on return so back-to-back beats need no re-raise
	task automatic send(logic cmd, logic signed [31:0] x, logic signed [31:0] y);
		start <= 1'b1;
		command <= cmd;
		x_value <= x;
		y_value <= y;
		do
			@(posedge clk);
		while (busy);
		sb.note_beat(cmd, x, y);
		beats++;
		// bursty sender: random gaps between bursts, some bursts without gaps
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(0, 15);
		end
	endtask

	// window length is only touched with the block idle and nothing owed
	task automatic write_length(logic [8:0] v);
		start <= 1'b0;
		@(posedge clk);
		while (busy || sb.owed.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		window_length_we <= 1'b1;
		window_length <= v;
		@(posedge clk);
		window_length_we <= 1'b0;
		sb.set_length(v);
	endtask

	function automatic logic signed [31:0] pick_value(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(0, 4)) - 2;
			2: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(0, 2000)) - 1000;
		endcase
	endfunction

	// a random run of adds in a chosen shape, at times a full window or more, then a fit request
	task automatic run_group();
		int shape, cnt;
		logic signed [31:0] x, y, x0, y0, k;
		shape = $urandom_range(0, 5);
		x0 = pick_value($urandom_range(0, 3));
		y0 = pick_value($urandom_range(0, 3));
		k = $signed($urandom_range(0, 20)) - 10;
		if ($urandom_range(0, 7) == 0)
			cnt = sb.wlen + $urandom_range(0, 4);
		else
			cnt = $urandom_range(0, (sb.wlen < 36) ? sb.wlen + 4 : 40);
		for (int i = 0; i < cnt; i++) begin
			x = pick_value($urandom_range(0, 3));
			y = pick_value($urandom_range(0, 3));
			case (shape)
				0: x = x0;                            // x flat
				1: y = y0;                            // y flat
				2: y = k * (x % 1000) + y0 % 1000 + $signed($urandom_range(0, 6)) - 3;
				3: y = -x;                            // negative line, but -2^31 stays -2^31
				default: ;
			endcase
			send(CMD_ADD, x, y);
		end
		send(CMD_CALC, $urandom, $urandom);
	endtask

	initial begin
		logic [8:0] lens [10] = '{9'd1, 9'd0, 9'd2, 9'd511, 9'd3, 9'd300, 9'd7,
			9'd256, 9'd16, 9'd5};
		int phase;
		logic signed [31:0] mn, mx;
		mn = 32'sh80000000;
		mx = 32'sh7fffffff;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty window, single sample, extremes, flat cases, wrap
		send(CMD_CALC, 0, 0);
		send(CMD_ADD, mn, mn);
		send(CMD_CALC, 0, 0);
		send(CMD_ADD, mx, mx);
		send(CMD_CALC, 0, 0);
		send(CMD_ADD, mn, mx);
		send(CMD_ADD, mx, mn);
		send(CMD_CALC, -1, -1);
		write_length(9'd4);
		send(CMD_ADD, 1, 5);
		send(CMD_ADD, 2, 5);
		send(CMD_ADD, 3, 5);
		send(CMD_CALC, 0, 0);
		send(CMD_ADD, 7, 1);
		send(CMD_ADD, 7, -9);
		send(CMD_ADD, 7, 4);
		send(CMD_ADD, 7, 3);
		send(CMD_CALC, 0, 0);
		send(CMD_ADD, 1, 2);
		send(CMD_ADD, 2, 4);
		send(CMD_CALC, 0, 0);

		phase = 0;
		while (beats < 1450) begin
			write_length((phase < 10) ? lens[phase] : 9'($urandom_range(0, 511)));
			phase++;
			for (int g = 0; g < 8; g++)
				run_group();
		end
		write_length(9'd256);
		run_group();

		start <= 1'b0;
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.owed.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+rtl
rtl/swlr_pkg.sv
rtl/swlr_alu.sv
rtl/swlr_dpath.sv
rtl/swlr_ctrl.sv
rtl/sliding_window_linear_regression_core.sv
sim/testbench.sv
